FILE: sv/sia_pkg.sv
// Shared types, codes and helper functions for the saturating interval ALU.
package sia_pkg;

   // Word geometry and the infinity codes.
   localparam int WORD_W = 64;
   localparam int CMD_W  = 5;
   localparam int CNT_W  = 6;
   localparam int BITS_W = 7;
   localparam logic signed [WORD_W-1:0] NEG_INF     = 64'sh8000_0000_0000_0000;
   localparam logic signed [WORD_W-1:0] POS_INF     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WORD_W-1:0] SHIFT_LIMIT = 64'sd63;

   // Operation codes.
   localparam logic [CMD_W-1:0] CMD_ADD   = 5'd0;
   localparam logic [CMD_W-1:0] CMD_SUB   = 5'd1;
   localparam logic [CMD_W-1:0] CMD_MUL   = 5'd2;
   localparam logic [CMD_W-1:0] CMD_FDIV  = 5'd3;
   localparam logic [CMD_W-1:0] CMD_FMOD  = 5'd4;
   localparam logic [CMD_W-1:0] CMD_MIN   = 5'd5;
   localparam logic [CMD_W-1:0] CMD_MAX   = 5'd6;
   localparam logic [CMD_W-1:0] CMD_POW   = 5'd7;
   localparam logic [CMD_W-1:0] CMD_AND   = 5'd8;
   localparam logic [CMD_W-1:0] CMD_OR    = 5'd9;
   localparam logic [CMD_W-1:0] CMD_SHL   = 5'd10;
   localparam logic [CMD_W-1:0] CMD_SHR   = 5'd11;
   localparam logic [CMD_W-1:0] CMD_NEG   = 5'd12;
   localparam logic [CMD_W-1:0] CMD_ABS   = 5'd13;
   localparam logic [CMD_W-1:0] CMD_CAST  = 5'd14;
   localparam logic [CMD_W-1:0] CMD_BOOL  = 5'd15;

   // How a transaction is worked out.
   typedef enum logic [2:0] {
      CLS_SIMPLE = 3'd0,
      CLS_MUL4   = 3'd1,
      CLS_DIV    = 3'd2,
      CLS_POW    = 3'd3,
      CLS_SHL    = 3'd4
   } cls_type;

   // Source of a bound written during pow.
   typedef enum logic [1:0] {
      SRC_BASE  = 2'd0,
      SRC_PROD  = 2'd1,
      SRC_ACC   = 2'd2,
      SRC_SQSAT = 2'd3
   } pow_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        quick;
      logic        mul_start;
      logic        mul_sq;
      logic        div_start;
      logic        unit_wr;
      logic        pow_init;
      logic        pow_shift;
      logic        acc_wr;
      logic        sq_wr;
      logic        pow_set;
      pow_src_type pow_src;
      logic [1:0]  job;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cls_type cls;
      logic    mul_done;
      logic    div_done;
      logic    prod_inf;
      logic    e_odd;
      logic    e_last;
      logic    base_trivial;
   } ctrl_stat_type;

   // Absolute value as an unsigned word; the most negative value gives 2^63.
   function automatic logic [WORD_W-1:0] magnitude(input logic signed [WORD_W-1:0] x);
      logic [WORD_W-1:0] u;
      u = x;
      return x[WORD_W-1] ? (~u + 64'd1) : u;
   endfunction

endpackage

FILE: sv/sia_if.sv
// Request and response channel interfaces of the saturating interval ALU.
interface sia_req_if import sia_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [WORD_W-1:0] a_min;
   logic signed [WORD_W-1:0] a_max;
   logic signed [WORD_W-1:0] b_min;
   logic signed [WORD_W-1:0] b_max;
   logic                     cast_is_integer;
   logic                     cast_unsigned;
   logic [BITS_W-1:0]        cast_bits;

   modport source(output valid, command, a_min, a_max, b_min, b_max,
                  cast_is_integer, cast_unsigned, cast_bits, input ready);
   modport sink(input valid, command, a_min, a_max, b_min, b_max,
                cast_is_integer, cast_unsigned, cast_bits, output ready);
endinterface

interface sia_rsp_if import sia_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] res_min;
   logic signed [WORD_W-1:0] res_max;

   modport source(output valid, res_min, res_max, input ready);
   modport sink(input valid, res_min, res_max, output ready);
endinterface

FILE: sv/sia_mul.sv
// Bit-serial saturating signed 64-bit multiplier, one multiplier bit per cycle.
module sia_mul import sia_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WORD_W-1:0] x,
   input  logic signed [WORD_W-1:0] y,
   output logic                     done,
   output logic signed [WORD_W-1:0] product
);

   localparam logic [WORD_W+1:0] CAP     = {2'b00, 1'b1, 62'd0, 1'b1};
   localparam logic [WORD_W:0]   LIM_POS = {2'b00, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W:0]   LIM_NEG = {2'b01, {(WORD_W-1){1'b0}}};

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [WORD_W-1:0]        ux_ff, ux_in;
   logic [WORD_W-1:0]        uy_ff, uy_in;
   logic [WORD_W:0]          acc_ff, acc_in;
   logic                     pos_ff, pos_in;
   logic                     spec_ff, spec_in;
   logic signed [WORD_W-1:0] spec_val_ff, spec_val_in;
   logic [WORD_W+1:0]        sum;
   logic                     ovf;
   logic [WORD_W-1:0]        mag_lo;

   // Shift-add step with the partial product capped just above 2^63.
   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      ux_in       = ux_ff;
      uy_in       = uy_ff;
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      spec_in     = spec_ff;
      spec_val_in = spec_val_ff;
      sum = {acc_ff, 1'b0} + {2'b00, (uy_ff[WORD_W-1] ? ux_ff : {WORD_W{1'b0}})};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ux_in   = magnitude(x);
         uy_in   = magnitude(y);
         acc_in  = '0;
         pos_in  = (x > 64'sd0) == (y > 64'sd0);
         spec_in = (x == 64'sd0) || (y == 64'sd0) || (x == POS_INF) || (x == NEG_INF)
                   || (y == POS_INF) || (y == NEG_INF);
         if ((x == 64'sd0) || (y == 64'sd0)) begin
            spec_val_in = '0;
         end else begin
            spec_val_in = ((x > 64'sd0) == (y > 64'sd0)) ? POS_INF : NEG_INF;
         end
      end else if (busy_ff) begin
         acc_in = (sum > CAP) ? CAP[WORD_W:0] : sum[WORD_W:0];
         uy_in  = {uy_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == {CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      acc_ff      <= acc_in;
      pos_ff      <= pos_in;
      spec_ff     <= spec_in;
      spec_val_ff <= spec_val_in;
   end

   // Final saturation against the signed range for the product's sign.
   always_comb begin
      ovf    = acc_ff > (pos_ff ? LIM_POS : LIM_NEG);
      mag_lo = acc_ff[WORD_W-1:0];
      if (spec_ff) begin
         product = spec_val_ff;
      end else if (ovf) begin
         product = pos_ff ? POS_INF : NEG_INF;
      end else if (pos_ff) begin
         product = $signed(mag_lo);
      end else begin
         product = $signed(~mag_lo + 64'd1);
      end
   end

   assign done = done_ff;

endmodule

FILE: sv/sia_div.sv
// Restoring floor divider for a positive divisor, one quotient bit per cycle.
module sia_div import sia_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WORD_W-1:0] x,
   input  logic signed [WORD_W-1:0] y,
   output logic                     done,
   output logic signed [WORD_W-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [WORD_W-1:0]        dq_ff, dq_in;
   logic [WORD_W-1:0]        rem_ff, rem_in;
   logic [WORD_W-1:0]        yv_ff, yv_in;
   logic                     neg_ff, neg_in;
   logic                     spec_ff, spec_in;
   logic signed [WORD_W-1:0] spec_val_ff, spec_val_in;
   logic [WORD_W-1:0]        trial;
   logic [WORD_W-1:0]        uq;

   // One restoring step: shift in a dividend bit, subtract if it fits.
   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      yv_in       = yv_ff;
      neg_in      = neg_ff;
      spec_in     = spec_ff;
      spec_val_in = spec_val_ff;
      trial       = {rem_ff[WORD_W-2:0], dq_ff[WORD_W-1]};
      if (start) begin
         busy_in     = 1'b1;
         cnt_in      = '0;
         dq_in       = magnitude(x);
         rem_in      = '0;
         yv_in       = y;
         neg_in      = x[WORD_W-1];
         spec_in     = (x == POS_INF) || (x == NEG_INF) || (y <= 64'sd0);
         spec_val_in = ((x == POS_INF) || (x == NEG_INF)) ? x : '0;
      end else if (busy_ff) begin
         if (trial >= yv_ff) begin
            rem_in = trial - yv_ff;
            dq_in  = {dq_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            dq_in  = {dq_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == {CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      yv_ff       <= yv_in;
      neg_ff      <= neg_in;
      spec_ff     <= spec_in;
      spec_val_ff <= spec_val_in;
   end

   // Negative dividends round toward minus infinity.
   always_comb begin
      uq = dq_ff + {63'd0, (neg_ff && (rem_ff != '0))};
      if (spec_ff) begin
         quotient = spec_val_ff;
      end else if (neg_ff) begin
         quotient = $signed(~uq + 64'd1);
      end else begin
         quotient = $signed(dq_ff);
      end
   end

   assign done = done_ff;

endmodule

FILE: sv/sia_datapath.sv
// Operand and result registers, combinational operations and the shared mul/div units.
module sia_datapath import sia_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output ctrl_stat_type            stat,
   input  logic [CMD_W-1:0]         item_command,
   input  logic signed [WORD_W-1:0] item_a_min,
   input  logic signed [WORD_W-1:0] item_a_max,
   input  logic signed [WORD_W-1:0] item_b_min,
   input  logic signed [WORD_W-1:0] item_b_max,
   input  logic                     item_cast_is_integer,
   input  logic                     item_cast_unsigned,
   input  logic [BITS_W-1:0]        item_cast_bits,
   output logic signed [WORD_W-1:0] res_min,
   output logic signed [WORD_W-1:0] res_max
);

   typedef logic signed [WORD_W-1:0] word_type;

   function automatic word_type sat_neg(input word_type v);
      if (v == POS_INF) return NEG_INF;
      if (v == NEG_INF) return POS_INF;
      return -v;
   endfunction

   function automatic word_type sat_add(input word_type p, input word_type q);
      logic signed [WORD_W:0] s;
      s = {p[WORD_W-1], p} + {q[WORD_W-1], q};
      if ((p == POS_INF) || (q == POS_INF)) return POS_INF;
      if ((p == NEG_INF) || (q == NEG_INF)) return NEG_INF;
      if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? NEG_INF : POS_INF;
      return s[WORD_W-1:0];
   endfunction

   function automatic word_type smin(input word_type p, input word_type q);
      return (p < q) ? p : q;
   endfunction

   function automatic word_type smax(input word_type p, input word_type q);
      return (p > q) ? p : q;
   endfunction

   logic [CMD_W-1:0]  cmd_ff;
   word_type          a_lo_ff, a_hi_ff, b_lo_ff, b_hi_ff;
   logic              cast_int_ff, cast_uns_ff;
   logic [BITS_W-1:0] cast_bits_ff;
   word_type          res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   word_type          acc_ff, acc_in, sq_ff, sq_in;
   logic [WORD_W-2:0] e_ff, e_in;

   word_type          q_lo, q_hi;
   cls_type           cls;
   logic              shift_ok;
   word_type          top, t_min, t_max, half;
   logic [5:0]        sh_lo;
   word_type          da_lo, da_hi, db_lo, db_hi;
   word_type          div_x, div_y, mul_x, mul_y;
   word_type          prod, quot, base, sqsat, pow_val;
   logic              mul_done, div_done;

   // Shift conditions shared by both shift commands.
   assign shift_ok = (a_lo_ff >= 64'sd0) && (b_lo_ff >= 64'sd0)
                     && (b_hi_ff < SHIFT_LIMIT) && (b_lo_ff < SHIFT_LIMIT);

   // Operations worked out combinationally, and the class of the transaction.
   always_comb begin
      q_lo  = NEG_INF;
      q_hi  = POS_INF;
      cls   = CLS_SIMPLE;
      top   = sat_add(b_hi_ff, -64'sd1);
      sh_lo = (b_hi_ff < 64'sd0) ? 6'd0 : b_hi_ff[5:0];
      half  = $signed(64'd1 << (cast_bits_ff[5:0] - 6'd1));
      if (cast_uns_ff) begin
         t_min = '0;
         t_max = $signed((64'd1 << cast_bits_ff[5:0]) - 64'd1);
      end else begin
         t_min = -half;
         t_max = half - 64'sd1;
      end
      case (cmd_ff)
         CMD_ADD: begin
            q_lo = sat_add(a_lo_ff, b_lo_ff);
            q_hi = sat_add(a_hi_ff, b_hi_ff);
         end
         CMD_SUB: begin
            q_lo = sat_add(a_lo_ff, sat_neg(b_hi_ff));
            q_hi = sat_add(a_hi_ff, sat_neg(b_lo_ff));
         end
         CMD_MUL: cls = CLS_MUL4;
         CMD_FDIV: begin
            if ((b_lo_ff > 64'sd0) || (b_hi_ff < 64'sd0)) cls = CLS_DIV;
         end
         CMD_FMOD: begin
            if (b_lo_ff > 64'sd0) begin
               q_lo = '0;
               q_hi = (a_lo_ff >= 64'sd0) ? smin(a_hi_ff, top) : top;
            end
         end
         CMD_MIN: begin
            q_lo = smin(a_lo_ff, b_lo_ff);
            q_hi = smin(a_hi_ff, b_hi_ff);
         end
         CMD_MAX: begin
            q_lo = smax(a_lo_ff, b_lo_ff);
            q_hi = smax(a_hi_ff, b_hi_ff);
         end
         CMD_POW: begin
            if ((b_lo_ff == b_hi_ff) && (b_lo_ff >= 64'sd0)) begin
               if (b_lo_ff == 64'sd0) begin
                  q_lo = 64'sd1;
                  q_hi = 64'sd1;
               end else if (b_lo_ff == 64'sd1) begin
                  q_lo = a_lo_ff;
                  q_hi = a_hi_ff;
               end else if (a_lo_ff >= 64'sd0) begin
                  cls = CLS_POW;
               end
            end
         end
         CMD_AND: begin
            if ((a_lo_ff >= 64'sd0) && (b_lo_ff >= 64'sd0)) begin
               q_lo = '0;
               q_hi = smin(a_hi_ff, b_hi_ff);
            end
         end
         CMD_OR: begin
            if ((a_lo_ff >= 64'sd0) && (b_lo_ff >= 64'sd0)) begin
               q_lo = smax(a_lo_ff, b_lo_ff);
               q_hi = sat_add(a_hi_ff, b_hi_ff);
            end
         end
         CMD_SHL: begin
            if (shift_ok) cls = CLS_SHL;
         end
         CMD_SHR: begin
            if (shift_ok) begin
               q_lo = a_lo_ff >>> sh_lo;
               q_hi = a_hi_ff >>> b_lo_ff[5:0];
            end
         end
         CMD_NEG: begin
            q_lo = sat_neg(a_hi_ff);
            q_hi = sat_neg(a_lo_ff);
         end
         CMD_ABS: begin
            if (a_lo_ff >= 64'sd0) begin
               q_lo = a_lo_ff;
               q_hi = a_hi_ff;
            end else if (a_hi_ff <= 64'sd0) begin
               q_lo = sat_neg(a_hi_ff);
               q_hi = sat_neg(a_lo_ff);
            end else begin
               q_lo = '0;
               q_hi = smax(sat_neg(a_lo_ff), a_hi_ff);
            end
         end
         CMD_CAST: begin
            if (cast_int_ff) begin
               if ((cast_bits_ff == '0) || cast_bits_ff[BITS_W-1]) begin
                  q_lo = a_lo_ff;
                  q_hi = a_hi_ff;
               end else begin
                  q_lo = smax(a_lo_ff, t_min);
                  q_hi = smin(a_hi_ff, t_max);
               end
            end
         end
         CMD_BOOL: begin
            q_lo = '0;
            q_hi = 64'sd1;
         end
         default: begin
            q_lo = NEG_INF;
            q_hi = POS_INF;
         end
      endcase
   end

   // Divider operands: a negative divisor range negates both operands first.
   always_comb begin
      if (b_lo_ff > 64'sd0) begin
         da_lo = a_lo_ff;
         da_hi = a_hi_ff;
         db_lo = b_lo_ff;
         db_hi = b_hi_ff;
      end else begin
         da_lo = sat_neg(a_hi_ff);
         da_hi = sat_neg(a_lo_ff);
         db_lo = sat_neg(b_hi_ff);
         db_hi = sat_neg(b_lo_ff);
      end
      if (cmd.job[0]) begin
         div_x = da_hi;
         div_y = (da_hi >= 64'sd0) ? db_lo : db_hi;
      end else begin
         div_x = da_lo;
         div_y = (da_lo >= 64'sd0) ? db_hi : db_lo;
      end
   end

   // Multiplier operands: four corners, shift as multiply, or pow steps.
   always_comb begin
      base = cmd.job[0] ? a_hi_ff : a_lo_ff;
      case (cls)
         CLS_MUL4: begin
            mul_x = cmd.job[1] ? a_hi_ff : a_lo_ff;
            mul_y = cmd.job[0] ? b_hi_ff : b_lo_ff;
         end
         CLS_SHL: begin
            mul_x = base;
            mul_y = $signed(64'd1 << (cmd.job[0] ? b_hi_ff[5:0] : b_lo_ff[5:0]));
         end
         default: begin
            mul_x = cmd.mul_sq ? sq_ff : acc_ff;
            mul_y = sq_ff;
         end
      endcase
   end

   sia_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .done    (mul_done),
      .product (prod)
   );

   sia_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .x        (div_x),
      .y        (div_y),
      .done     (div_done),
      .quotient (quot)
   );

   // Value of a pow bound that finishes now.
   always_comb begin
      sqsat = ((acc_ff > 64'sd0) == ((base > 64'sd0) || !b_lo_ff[0])) ? POS_INF : NEG_INF;
      case (cmd.pow_src)
         SRC_BASE: pow_val = base;
         SRC_PROD: pow_val = prod;
         SRC_ACC:  pow_val = acc_ff;
         default:  pow_val = sqsat;
      endcase
   end

   // Result and pow working registers.
   always_comb begin
      res_lo_in = res_lo_ff;
      res_hi_in = res_hi_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      e_in      = e_ff;
      if (cmd.quick) begin
         res_lo_in = q_lo;
         res_hi_in = q_hi;
      end
      if (cmd.unit_wr) begin
         case (cls)
            CLS_MUL4: begin
               res_lo_in = (cmd.job == 2'd0) ? prod : smin(res_lo_ff, prod);
               res_hi_in = (cmd.job == 2'd0) ? prod : smax(res_hi_ff, prod);
            end
            CLS_DIV: begin
               if (cmd.job[0]) res_hi_in = quot;
               else            res_lo_in = quot;
            end
            default: begin
               if (cmd.job[0]) res_hi_in = prod;
               else            res_lo_in = prod;
            end
         endcase
      end
      if (cmd.pow_set) begin
         if (cmd.job[0]) res_hi_in = pow_val;
         else            res_lo_in = pow_val;
      end
      if (cmd.pow_init) begin
         acc_in = 64'sd1;
         sq_in  = base;
         e_in   = b_lo_ff[WORD_W-2:0];
      end
      if (cmd.acc_wr)    acc_in = prod;
      if (cmd.sq_wr)     sq_in  = prod;
      if (cmd.pow_shift) e_in   = e_ff >> 1;
   end

   // Payload registers; nothing here needs a reset.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff       <= item_command;
         a_lo_ff      <= item_a_min;
         a_hi_ff      <= item_a_max;
         b_lo_ff      <= item_b_min;
         b_hi_ff      <= item_b_max;
         cast_int_ff  <= item_cast_is_integer;
         cast_uns_ff  <= item_cast_unsigned;
         cast_bits_ff <= item_cast_bits;
      end
      res_lo_ff <= res_lo_in;
      res_hi_ff <= res_hi_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      e_ff      <= e_in;
   end

   always_comb begin
      stat.cls          = cls;
      stat.mul_done     = mul_done;
      stat.div_done     = div_done;
      stat.prod_inf     = (prod == POS_INF) || (prod == NEG_INF);
      stat.e_odd        = e_ff[0];
      stat.e_last       = (e_ff[WORD_W-2:1] == '0);
      stat.base_trivial = (base == 64'sd0) || (base == 64'sd1);
   end

   assign res_min = res_lo_ff;
   assign res_max = res_hi_ff;

endmodule

FILE: sv/sia_ctrl.sv
// Control state machine that sequences the datapath for one transaction at a time.
module sia_ctrl import sia_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b00_0000_0001,
      ST_DECODE     = 10'b00_0000_0010,
      ST_ISSUE      = 10'b00_0000_0100,
      ST_WAIT       = 10'b00_0000_1000,
      ST_POW_INIT   = 10'b00_0001_0000,
      ST_POW_STEP   = 10'b00_0010_0000,
      ST_POW_WAIT_A = 10'b00_0100_0000,
      ST_POW_SHIFT  = 10'b00_1000_0000,
      ST_POW_WAIT_S = 10'b01_0000_0000,
      ST_DONE       = 10'b10_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] job_ff, job_in;
   logic       last_job;

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cmd       = '0;
      cmd.job   = job_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      last_job  = (stat.cls == CLS_MUL4) ? (job_ff == 2'd3) : (job_ff == 2'd1);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            job_in = '0;
            case (stat.cls)
               CLS_SIMPLE: begin
                  cmd.quick = 1'b1;
                  state_in  = ST_DONE;
               end
               CLS_POW: state_in = ST_POW_INIT;
               default: state_in = ST_ISSUE;
            endcase
         end
         ST_ISSUE: begin
            if (stat.cls == CLS_DIV) cmd.div_start = 1'b1;
            else                     cmd.mul_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.mul_done || stat.div_done) begin
               cmd.unit_wr = 1'b1;
               if (last_job) begin
                  state_in = ST_DONE;
               end else begin
                  job_in   = job_ff + 2'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_POW_INIT: begin
            cmd.pow_init = 1'b1;
            if (stat.base_trivial) begin
               cmd.pow_set = 1'b1;
               cmd.pow_src = SRC_BASE;
               job_in      = 2'd1;
               state_in    = job_ff[0] ? ST_DONE : ST_POW_INIT;
            end else begin
               state_in = ST_POW_STEP;
            end
         end
         ST_POW_STEP: begin
            if (stat.e_odd) begin
               cmd.mul_start = 1'b1;
               state_in      = ST_POW_WAIT_A;
            end else begin
               state_in = ST_POW_SHIFT;
            end
         end
         ST_POW_WAIT_A: begin
            if (stat.mul_done) begin
               cmd.acc_wr = 1'b1;
               if (stat.prod_inf) begin
                  cmd.pow_set = 1'b1;
                  cmd.pow_src = SRC_PROD;
                  job_in      = 2'd1;
                  state_in    = job_ff[0] ? ST_DONE : ST_POW_INIT;
               end else begin
                  state_in = ST_POW_SHIFT;
               end
            end
         end
         ST_POW_SHIFT: begin
            cmd.pow_shift = 1'b1;
            if (stat.e_last) begin
               cmd.pow_set = 1'b1;
               cmd.pow_src = SRC_ACC;
               job_in      = 2'd1;
               state_in    = job_ff[0] ? ST_DONE : ST_POW_INIT;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sq    = 1'b1;
               state_in      = ST_POW_WAIT_S;
            end
         end
         ST_POW_WAIT_S: begin
            if (stat.mul_done) begin
               if (stat.prod_inf) begin
                  cmd.pow_set = 1'b1;
                  cmd.pow_src = SRC_SQSAT;
                  job_in      = 2'd1;
                  state_in    = job_ff[0] ? ST_DONE : ST_POW_INIT;
               end else begin
                  cmd.sq_wr = 1'b1;
                  state_in  = ST_POW_STEP;
               end
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

endmodule

FILE: sv/saturating_interval_alu.sv
// Saturating interval ALU on 64-bit signed bounds; one transaction in flight at a time.
// Simple operations are written from the registered operands; mul runs four multiplies,
// floordiv and shl two runs of the bit-serial divider or multiplier, and pow one multiplier
// run for each multiply step. A new transaction is accepted in the cycle after the response
// is taken. Synchronous active-high reset returns the controller to idle; no clearing pass
// is needed.
module saturating_interval_alu import sia_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sia_req_if.sink   req_if,
   sia_rsp_if.source rsp_if
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Sequencing of the transaction.
   sia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Operand storage and arithmetic.
   sia_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .item_command         (req_if.command),
      .item_a_min           (req_if.a_min),
      .item_a_max           (req_if.a_max),
      .item_b_min           (req_if.b_min),
      .item_b_max           (req_if.b_max),
      .item_cast_is_integer (req_if.cast_is_integer),
      .item_cast_unsigned   (req_if.cast_unsigned),
      .item_cast_bits       (req_if.cast_bits),
      .res_min              (rsp_if.res_min),
      .res_max              (rsp_if.res_max)
   );

endmodule

FILE: sv/sia_checker.sv
// Port-level assertions for the saturating interval ALU and their bind.
module sia_checker import sia_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [WORD_W-1:0] rsp_res_min,
   input logic signed [WORD_W-1:0] rsp_res_max
);

   logic pend_ff, pend_in;

   // One outstanding transaction between request and response.
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready) pend_in = 1'b1;
      if (rsp_valid && rsp_ready) pend_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_res_min) && $stable(rsp_res_max))
      else $error("response payload changed while stalled");

   rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff)
      else $error("response without an accepted request");

   req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !pend_ff)
      else $error("request accepted while a transaction is outstanding");

endmodule

bind saturating_interval_alu sia_checker u_sia_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_res_min (rsp_if.res_min),
   .rsp_res_max (rsp_if.res_max)
);

FILE: bench/sia_tb_if.sv
// Bench-side types for one request transaction and one expected result interval.
package sia_tb_types;
   import sia_pkg::*;
   // One request transaction as the bench sees it.
   typedef struct {
      logic [CMD_W-1:0]         command;
      logic signed [WORD_W-1:0] a_min;
      logic signed [WORD_W-1:0] a_max;
      logic signed [WORD_W-1:0] b_min;
      logic signed [WORD_W-1:0] b_max;
      logic                     cast_is_integer;
      logic                     cast_unsigned;
      logic [BITS_W-1:0]        cast_bits;
   } alu_req_type;

   // One expected result interval.
   typedef struct {
      logic signed [WORD_W-1:0] lo;
      logic signed [WORD_W-1:0] hi;
   } bounds_type;
endpackage

FILE: bench/saturating_interval_alu_tb.sv
// Self-checking bench for the saturating interval ALU with random traffic and backpressure.
module saturating_interval_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sia_pkg::*;
   import sia_tb_types::*;

   typedef logic signed [WORD_W-1:0] word_type;

   // Saturating arithmetic used to predict each bound.
   function automatic word_type sadd(word_type x, word_type y);
      word_type s;
      if (x == POS_INF || y == POS_INF) return POS_INF;
      if (x == NEG_INF || y == NEG_INF) return NEG_INF;
      s = x + y;
      if (!x[63] && !y[63] && s[63]) return POS_INF;
      if (x[63] && y[63] && !s[63]) return NEG_INF;
      return s;
   endfunction

   function automatic word_type sneg(word_type x);
      if (x == POS_INF) return NEG_INF;
      if (x == NEG_INF) return POS_INF;
      return -x;
   endfunction

   function automatic word_type smul(word_type x, word_type y);
      logic pos;
      logic [63:0] ux, uy;
      logic [127:0] p;
      if (x == 0 || y == 0) return 0;
      pos = (x > 0) == (y > 0);
      if (x == POS_INF || x == NEG_INF || y == POS_INF || y == NEG_INF)
         return pos ? POS_INF : NEG_INF;
      ux = x[63] ? -x : x;
      uy = y[63] ? -y : y;
      p = ux * uy;
      if (pos) return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? POS_INF : word_type'(p[63:0]);
      return (p > 128'h8000_0000_0000_0000) ? NEG_INF : word_type'(-p[63:0]);
   endfunction

   function automatic word_type spow(word_type base, word_type ex);
      word_type acc, sq, e;
      acc = 1; sq = base; e = ex;
      if (ex == 0) return 1;
      if (base == 0) return 0;
      if (base == 1) return 1;
      while (e > 0) begin
         if (e[0]) begin
            acc = smul(acc, sq);
            if (acc == POS_INF || acc == NEG_INF) return acc;
         end
         e = e >>> 1;
         if (e > 0) begin
            sq = smul(sq, sq);
            if (sq == POS_INF || sq == NEG_INF)
               return ((acc > 0) == (base > 0 || !ex[0])) ? POS_INF : NEG_INF;
         end
      end
      return acc;
   endfunction

   // Floor quotient for a positive divisor; infinite dividends stay put.
   function automatic word_type floor_quot(word_type x, word_type y);
      word_type q;
      if (x == POS_INF || x == NEG_INF) return x;
      if (y <= 0) return 0;
      q = x / y;
      if (x < 0 && q * y != x) q = q - 1;
      return q;
   endfunction

   function automatic bounds_type div_pos(word_type alo, word_type ahi, word_type blo,
                                          word_type bhi);
      bounds_type r;
      r.lo = (alo >= 0) ? floor_quot(alo, bhi) : floor_quot(alo, blo);
      r.hi = (ahi >= 0) ? floor_quot(ahi, blo) : floor_quot(ahi, bhi);
      return r;
   endfunction

   function automatic word_type wmin(word_type x, word_type y);
      return x < y ? x : y;
   endfunction
   function automatic word_type wmax(word_type x, word_type y);
      return x > y ? x : y;
   endfunction

   // Predicts the result interval of one request.
   function automatic bounds_type predict_interval(alu_req_type q);
      bounds_type r;
      word_type v0, v1, v2, v3, tmin, tmax;
      r.lo = NEG_INF; r.hi = POS_INF;
      case (q.command)
         CMD_ADD: begin
            r.lo = sadd(q.a_min, q.b_min); r.hi = sadd(q.a_max, q.b_max);
         end
         CMD_SUB: begin
            r.lo = sadd(q.a_min, sneg(q.b_max)); r.hi = sadd(q.a_max, sneg(q.b_min));
         end
         CMD_MUL: begin
            v0 = smul(q.a_min, q.b_min); v1 = smul(q.a_min, q.b_max);
            v2 = smul(q.a_max, q.b_min); v3 = smul(q.a_max, q.b_max);
            r.lo = wmin(wmin(v0, v1), wmin(v2, v3));
            r.hi = wmax(wmax(v0, v1), wmax(v2, v3));
         end
         CMD_FDIV: begin
            if (q.b_min > 0) r = div_pos(q.a_min, q.a_max, q.b_min, q.b_max);
            else if (q.b_max < 0)
               r = div_pos(sneg(q.a_max), sneg(q.a_min), sneg(q.b_max), sneg(q.b_min));
         end
         CMD_FMOD: begin
            if (q.b_min > 0) begin
               v0 = sadd(q.b_max, -1);
               r.lo = 0;
               r.hi = (q.a_min >= 0) ? wmin(q.a_max, v0) : v0;
            end
         end
         CMD_MIN: begin
            r.lo = wmin(q.a_min, q.b_min); r.hi = wmin(q.a_max, q.b_max);
         end
         CMD_MAX: begin
            r.lo = wmax(q.a_min, q.b_min); r.hi = wmax(q.a_max, q.b_max);
         end
         CMD_POW: begin
            if (q.b_min == q.b_max && q.b_min >= 0) begin
               if (q.b_min == 0) begin
                  r.lo = 1; r.hi = 1;
               end else if (q.b_min == 1) begin
                  r.lo = q.a_min; r.hi = q.a_max;
               end else if (q.a_min >= 0) begin
                  r.lo = spow(q.a_min, q.b_min); r.hi = spow(q.a_max, q.b_min);
               end
            end
         end
         CMD_AND: begin
            if (q.a_min >= 0 && q.b_min >= 0) begin
               r.lo = 0; r.hi = wmin(q.a_max, q.b_max);
            end
         end
         CMD_OR: begin
            if (q.a_min >= 0 && q.b_min >= 0) begin
               r.lo = wmax(q.a_min, q.b_min); r.hi = sadd(q.a_max, q.b_max);
            end
         end
         CMD_SHL: begin
            if (q.a_min >= 0 && q.b_min >= 0 && q.b_max < SHIFT_LIMIT
                && q.b_min < SHIFT_LIMIT) begin
               r.lo = smul(q.a_min, word_type'(64'd1 << q.b_min));
               r.hi = smul(q.a_max, word_type'(64'd1 << q.b_max));
            end
         end
         CMD_SHR: begin
            if (q.a_min >= 0 && q.b_min >= 0 && q.b_max < SHIFT_LIMIT
                && q.b_min < SHIFT_LIMIT) begin
               // An inverted amount with a negative top shifts by zero.
               r.lo = q.a_min >>> (q.b_max < 0 ? 0 : q.b_max[5:0]);
               r.hi = q.a_max >>> q.b_min[5:0];
            end
         end
         CMD_NEG: begin
            r.lo = sneg(q.a_max); r.hi = sneg(q.a_min);
         end
         CMD_ABS: begin
            if (q.a_min >= 0) begin
               r.lo = q.a_min; r.hi = q.a_max;
            end else if (q.a_max <= 0) begin
               r.lo = sneg(q.a_max); r.hi = sneg(q.a_min);
            end else begin
               r.lo = 0; r.hi = wmax(sneg(q.a_min), q.a_max);
            end
         end
         CMD_CAST: begin
            if (q.cast_is_integer) begin
               if (q.cast_bits == 0 || q.cast_bits >= 64) begin
                  r.lo = q.a_min; r.hi = q.a_max;
               end else begin
                  if (q.cast_unsigned) begin
                     tmin = 0;
                     tmax = word_type'((64'd1 << q.cast_bits) - 64'd1);
                  end else begin
                     tmin = -word_type'(64'd1 << (q.cast_bits - 1));
                     tmax = word_type'((64'd1 << (q.cast_bits - 1)) - 64'd1);
                  end
                  r.lo = wmax(q.a_min, tmin); r.hi = wmin(q.a_max, tmax);
               end
            end
         end
         CMD_BOOL: begin
            r.lo = 0; r.hi = 1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Holds expected intervals in order and checks each response.
   class interval_scoreboard;
      bounds_type pending[$];
      int         errors;

      function void note_request(alu_req_type q);
         pending.push_back(predict_interval(q));
      endfunction

      function void check_response(word_type lo, word_type hi);
         bounds_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response lo=%0d hi=%0d", $realtime, lo, hi);
            return;
         end
         e = pending.pop_front();
         if (lo !== e.lo) begin
            errors++;
            $display("%0t: res_min expected %0d actual %0d", $realtime, e.lo, lo);
         end
         if (hi !== e.hi) begin
            errors++;
            $display("%0t: res_max expected %0d actual %0d", $realtime, e.hi, hi);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   sia_req_if req_if();
   sia_rsp_if rsp_if();

   saturating_interval_alu u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   interval_scoreboard board = new();
   bit      long_hold;
   bit      hold_done;
   longint  cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on total run length.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 10_000_000) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Response checking at each accepted transaction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_response(rsp_if.res_min, rsp_if.res_max);
   end

   // Receiver stall pattern, with one long hold on request.
   initial begin
      int hold;
      rsp_if.ready <= 1'b0;
      hold_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold && !hold_done) begin
            rsp_if.ready <= 1'b0;
            for (hold = 0; hold < 2000; hold++) @(posedge clock);
            hold_done = 1;
         end
         case ($urandom_range(0, 3))
            0: rsp_if.ready <= 1'b0;
            default: rsp_if.ready <= 1'b1;
         endcase
         @(posedge clock);
      end
   end

   // Picks an interesting 64-bit bound.
   function automatic word_type pick_bound();
      case ($urandom_range(0, 9))
         0: return NEG_INF;
         1: return POS_INF;
         2: return 0;
         3: return word_type'($urandom_range(0, 8)) - 4;
         4, 5: return word_type'({$urandom, $urandom});
         6: return word_type'($signed($urandom_range(0, 2000)) - 1000);
         7: return word_type'({$urandom, $urandom}) >>> $urandom_range(1, 62);
         default: return word_type'($urandom_range(0, 100000));
      endcase
   endfunction

   function automatic alu_req_type random_request();
      alu_req_type q;
      word_type t;
      q.command = (($urandom_range(0, 19)) == 0) ? CMD_W'($urandom_range(16, 31))
                                                : CMD_W'($urandom_range(0, 15));
      q.a_min = pick_bound();
      q.a_max = pick_bound();
      q.b_min = pick_bound();
      q.b_max = pick_bound();
      // Mostly well-ordered intervals, so the narrow cases are reached.
      if ($urandom_range(0, 4) != 0) begin
         if (q.a_min > q.a_max) begin t = q.a_min; q.a_min = q.a_max; q.a_max = t; end
         if (q.b_min > q.b_max) begin t = q.b_min; q.b_min = q.b_max; q.b_max = t; end
      end
      if (q.command == CMD_SHL || q.command == CMD_SHR) begin
         if ($urandom_range(0, 3) != 0) begin
            q.b_min = word_type'($urandom_range(0, 62));
            q.b_max = word_type'($urandom_range(32'(q.b_min), 62));
         end
         if ($urandom_range(0, 1)) q.a_min = word_type'($urandom_range(0, 1000));
      end
      if (q.command == CMD_POW && $urandom_range(0, 3) != 0) begin
         q.b_min = word_type'($urandom_range(0, 70));
         q.b_max = q.b_min;
         q.a_min = word_type'($urandom_range(0, 20));
         q.a_max = $urandom_range(0, 3) == 0 ? pick_bound()
                                             : word_type'($urandom_range(0, 50));
      end
      q.cast_is_integer = ($urandom_range(0, 4) != 0);
      q.cast_unsigned = 1'($urandom_range(0, 1));
      q.cast_bits = BITS_W'($urandom_range(0, 127));
      return q;
   endfunction

   function automatic alu_req_type make_req(logic [CMD_W-1:0] c, word_type al, word_type ah,
                                            word_type bl, word_type bh);
      alu_req_type q;
      q.command = c; q.a_min = al; q.a_max = ah; q.b_min = bl; q.b_max = bh;
      q.cast_is_integer = 1'b1; q.cast_unsigned = 1'b0; q.cast_bits = 7'd8;
      return q;
   endfunction

   // Offers one request and waits until it is accepted.
   task automatic send_request(alu_req_type q);
      req_if.valid           <= 1'b1;
      req_if.command         <= q.command;
      req_if.a_min           <= q.a_min;
      req_if.a_max           <= q.a_max;
      req_if.b_min           <= q.b_min;
      req_if.b_max           <= q.b_max;
      req_if.cast_is_integer <= q.cast_is_integer;
      req_if.cast_unsigned   <= q.cast_unsigned;
      req_if.cast_bits       <= q.cast_bits;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(q);
   endtask

   task automatic idle_cycles(int n);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Stimulus: directed corners, then random bursts.
   initial begin
      alu_req_type dir[$];
      alu_req_type q;
      int burst;
      long_hold = 0;
      reset = 1'b1;
      req_if.valid <= 1'b0;
      req_if.command <= '0;
      req_if.a_min <= '0; req_if.a_max <= '0;
      req_if.b_min <= '0; req_if.b_max <= '0;
      req_if.cast_is_integer <= 1'b0; req_if.cast_unsigned <= 1'b0;
      req_if.cast_bits <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Opposite infinities in add, corner products and each operation.
      dir.push_back(make_req(CMD_ADD, POS_INF, NEG_INF, NEG_INF, POS_INF));
      dir.push_back(make_req(CMD_SUB, NEG_INF, POS_INF, NEG_INF, POS_INF));
      dir.push_back(make_req(CMD_MUL, NEG_INF, -3, 5, POS_INF));
      dir.push_back(make_req(CMD_MUL, -7, 9, -11, 13));
      dir.push_back(make_req(CMD_FDIV, -7, 20, 2, 3));
      dir.push_back(make_req(CMD_FDIV, NEG_INF, 7, -3, -2));
      dir.push_back(make_req(CMD_FDIV, 100, 200, 5, POS_INF));
      dir.push_back(make_req(CMD_FDIV, 1, 2, -1, 1));
      dir.push_back(make_req(CMD_FMOD, 3, 100, 1, POS_INF));
      dir.push_back(make_req(CMD_FMOD, -3, 100, 7, 9));
      dir.push_back(make_req(CMD_MIN, NEG_INF, POS_INF, 5, -5));
      dir.push_back(make_req(CMD_MAX, NEG_INF, POS_INF, 5, -5));
      dir.push_back(make_req(CMD_POW, 0, 3, 0, 0));
      dir.push_back(make_req(CMD_POW, -5, 3, 1, 1));
      dir.push_back(make_req(CMD_POW, 2, 3, 62, 62));
      dir.push_back(make_req(CMD_POW, 3, 1000, 5, 5));
      dir.push_back(make_req(CMD_AND, 0, 12, 3, 9));
      dir.push_back(make_req(CMD_OR, 4, POS_INF, 2, 9));
      dir.push_back(make_req(CMD_SHL, 1, POS_INF, 0, 62));
      dir.push_back(make_req(CMD_SHR, 1000, POS_INF, 62, 0));
      dir.push_back(make_req(CMD_SHL, 1, 2, 63, 0));
      dir.push_back(make_req(CMD_NEG, NEG_INF, POS_INF, 0, 0));
      dir.push_back(make_req(CMD_ABS, NEG_INF, 5, 0, 0));
      q = make_req(CMD_CAST, NEG_INF, POS_INF, 0, 0);
      q.cast_bits = 7'd1;
      dir.push_back(q);
      q.cast_unsigned = 1'b1; q.cast_bits = 7'd63;
      dir.push_back(q);
      q.cast_bits = 7'd127;
      dir.push_back(q);
      q.cast_is_integer = 1'b0;
      dir.push_back(q);
      dir.push_back(make_req(CMD_BOOL, 0, 0, 0, 0));
      dir.push_back(make_req(CMD_W'(31), 0, 0, 0, 0));
      foreach (dir[i]) send_request(dir[i]);

      // Pause until every expected result has come.
      wait_drained();

      // Random bursts; one long receiver hold partway through.
      for (int n = 0; n < 1000;) begin
         if (n == 300) long_hold = 1;
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && n < 1000; k++, n++)
            send_request(random_request());
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
      end

      wait_drained();
      repeat (600) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: saturating_interval_alu.f
sv/sia_pkg.sv
sv/sia_if.sv
sv/sia_mul.sv
sv/sia_div.sv
sv/sia_datapath.sv
sv/sia_ctrl.sv
sv/saturating_interval_alu.sv
sv/sia_checker.sv
bench/sia_tb_if.sv
bench/saturating_interval_alu_tb.sv
